// File: sv/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// Types, codes and threshold constants for the battery level monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

  // operation codes
  localparam logic FUNC_TICK      = 1'b0;
  localparam logic FUNC_RESET_CHK = 1'b1;

  // light modes
  localparam logic [2:0] LIGHT_OFF    = 3'd0;
  localparam logic [2:0] LIGHT_SLEEP  = 3'd1;
  localparam logic [2:0] LIGHT_LOCKED = 3'd2;
  localparam logic [2:0] LIGHT_TURBO  = 3'd3;
  localparam logic [2:0] LIGHT_STROBE = 3'd4;
  localparam logic [2:0] LIGHT_OTHER  = 3'd5;

  // battery status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ALERT = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CELL_COUNT    = 2'd0;
  localparam logic [1:0] CFG_NOMINAL_CELLS = 2'd1;
  localparam logic [1:0] CFG_LIFEPO4       = 2'd2;

  // indicator indices
  localparam logic [4:0] IDX_NONE   = 5'd0;
  localparam logic [4:0] IDX_GREEN  = 5'd1;
  localparam logic [4:0] IDX_YELLOW = 5'd2;
  localparam logic [4:0] IDX_RED    = 5'd3;
  localparam logic [4:0] IDX_ALERT  = 5'd12;
  localparam logic [4:0] IDX_LASER  = 5'd23;
  localparam logic [4:0] IDX_THROTTLE_OFS = 5'd13;

  localparam logic [6:0] THROTTLE_FULL = 7'd100;

  // per-cell thresholds in mV
  localparam logic [11:0] LI_FAULT_MV  = 12'd2700;
  localparam logic [11:0] LI_ALERT_MV  = 12'd3010;
  localparam logic [11:0] LI_CLEAR_MV  = 12'd3200;
  localparam logic [11:0] LFP_FAULT_MV = 12'd2150;
  localparam logic [11:0] LFP_ALERT_MV = 12'd2600;
  localparam logic [11:0] LFP_CLEAR_MV = 12'd2800;
  localparam logic [11:0] RED_MV       = 12'd3300;
  localparam logic [11:0] YELLOW_MV    = 12'd3700;
  localparam logic [11:0] BOOST_DROP_MV = 12'd200;
  localparam logic [11:0] RESET_CHK_MV = 12'd2750;

  typedef struct packed {
    logic       func;
    logic [15:0] voltage_mv;
    logic [2:0] light_mode;
    logic       laser_enabled;
    logic [6:0] throttle_pct;
    logic [4:0] led_index_now;
  } in_item_t;

  typedef struct packed {
    logic [4:0] led_index;
    logic [1:0] batt_status;
  } out_item_t;

  typedef struct packed {
    logic [3:0] cell_count;
    logic [3:0] nominal_cell_count;
    logic       lifepo4_mode;
  } cfg_t;

  // per-cell threshold times cell count; fits 16 bits for n up to 15
  function automatic logic [15:0] scale_mv(input logic [11:0] mv, input logic [3:0] n);
    scale_mv = 16'(mv) * 16'(n);
  endfunction

endpackage

// File: sv/blm_eval.sv
// ----------------------------------------------------------------------------
// blm_eval
// Status update with hysteresis and indicator index selection for one request.
// ----------------------------------------------------------------------------
module blm_eval (
  input  blm_pkg::in_item_t  item,
  input  blm_pkg::cfg_t      cfg,
  input  logic [1:0]         status,
  output logic [1:0]         status_next,
  output blm_pkg::out_item_t result
);

  logic [15:0] fault_th, alert_th, clear_th, red_th, yellow_th, chk_th;
  logic [11:0] red_mv, yellow_mv;
  logic        lit;
  logic        boost;
  logic [4:0]  idx;

  always_comb begin
    boost = (item.light_mode == blm_pkg::LIGHT_TURBO) ||
            (item.light_mode == blm_pkg::LIGHT_STROBE);
    lit = !(item.light_mode inside {blm_pkg::LIGHT_OFF, blm_pkg::LIGHT_SLEEP,
                                    blm_pkg::LIGHT_LOCKED});
    red_mv    = boost ? blm_pkg::RED_MV - blm_pkg::BOOST_DROP_MV : blm_pkg::RED_MV;
    yellow_mv = boost ? blm_pkg::YELLOW_MV - blm_pkg::BOOST_DROP_MV : blm_pkg::YELLOW_MV;

    fault_th  = blm_pkg::scale_mv(cfg.lifepo4_mode ? blm_pkg::LFP_FAULT_MV
                                                   : blm_pkg::LI_FAULT_MV, cfg.cell_count);
    alert_th  = blm_pkg::scale_mv(cfg.lifepo4_mode ? blm_pkg::LFP_ALERT_MV
                                                   : blm_pkg::LI_ALERT_MV, cfg.cell_count);
    clear_th  = blm_pkg::scale_mv(cfg.lifepo4_mode ? blm_pkg::LFP_CLEAR_MV
                                                   : blm_pkg::LI_CLEAR_MV, cfg.cell_count);
    red_th    = blm_pkg::scale_mv(red_mv, cfg.cell_count);
    yellow_th = blm_pkg::scale_mv(yellow_mv, cfg.cell_count);
    chk_th    = blm_pkg::scale_mv(blm_pkg::RESET_CHK_MV, cfg.nominal_cell_count);

    status_next = status;
    idx = item.led_index_now;

    if (item.func == blm_pkg::FUNC_RESET_CHK) begin
      if (item.voltage_mv > chk_th) begin
        status_next = blm_pkg::ST_OK;
      end
    end else begin
      case (item.light_mode)
        blm_pkg::LIGHT_OFF: begin
          if (item.laser_enabled && (item.led_index_now == blm_pkg::IDX_NONE)) begin
            idx = blm_pkg::IDX_LASER;
          end
        end
        blm_pkg::LIGHT_SLEEP: begin
          idx = blm_pkg::IDX_NONE;
        end
        default: begin
          if (lit) begin
            if (item.voltage_mv <= fault_th) begin
              status_next = blm_pkg::ST_FAULT;
            end else if (item.voltage_mv <= alert_th) begin
              status_next = blm_pkg::ST_ALERT;
            end else if (item.voltage_mv > clear_th) begin
              status_next = blm_pkg::ST_OK;
            end
            if (status_next == blm_pkg::ST_FAULT || status_next == blm_pkg::ST_ALERT) begin
              idx = blm_pkg::IDX_ALERT;
            end else if (item.voltage_mv <= red_th) begin
              idx = blm_pkg::IDX_RED;
            end else if (item.voltage_mv <= yellow_th) begin
              idx = blm_pkg::IDX_YELLOW;
            end else begin
              idx = blm_pkg::IDX_GREEN;
            end
          end
        end
      endcase
      if ((item.throttle_pct < blm_pkg::THROTTLE_FULL) &&
          (idx inside {[blm_pkg::IDX_GREEN:blm_pkg::IDX_RED]})) begin
        idx = idx + blm_pkg::IDX_THROTTLE_OFS;
      end
    end

    result.led_index   = idx;
    result.batt_status = status_next;
  end

endmodule

// File: sv/battery_level_monitor_core.sv
// ----------------------------------------------------------------------------
// battery_level_monitor_core
// Low-voltage monitor and side-indicator selector, one request per cycle.
// ----------------------------------------------------------------------------
//  channel  | signals                         | direction
//  in       | in_valid, in_stall, in_data     | request in
//  out      | out_valid, out_stall, out_data  | result out
//  cfg      | cfg_we, cfg_index, cfg_data     | register write
//
// One request per cycle unless stalled; input register, then result register.
// The status register updates as a request moves into the result register.
// rst clears valids, status (ok) and configuration (1 cell, 1 cell, Li-ion).
// in_stall rises only while the result register is held by out_stall.
module battery_level_monitor_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  blm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output blm_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  blm_pkg::cfg_t      cfg;
  blm_pkg::in_item_t  s1_item;
  logic               s1_valid;
  logic [1:0]         status;
  logic [1:0]         status_next;
  blm_pkg::out_item_t result;
  logic               out_free;
  logic               s1_go;
  logic               in_acc;

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_count         <= 4'd1;
      cfg.nominal_cell_count <= 4'd1;
      cfg.lifepo4_mode       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        blm_pkg::CFG_CELL_COUNT:    cfg.cell_count         <= cfg_data;
        blm_pkg::CFG_NOMINAL_CELLS: cfg.nominal_cell_count <= cfg_data;
        blm_pkg::CFG_LIFEPO4:       cfg.lifepo4_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item <= in_data;
    end
  end

  blm_eval u_eval (
    .item        (s1_item),
    .cfg         (cfg),
    .status      (status),
    .status_next (status_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= blm_pkg::ST_OK;
      out_valid <= 1'b0;
    end else if (s1_go) begin
      status    <= status_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data <= result;
    end
  end

endmodule

// File: sv/blm_chk.sv
// ----------------------------------------------------------------------------
// blm_chk
// Port-level checks for the battery level monitor, bound to the top level.
// ----------------------------------------------------------------------------
module blm_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input blm_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.batt_status == blm_pkg::ST_OK) ||
                  (out_data.batt_status == blm_pkg::ST_ALERT) ||
                  (out_data.batt_status == blm_pkg::ST_FAULT))
    else $error("invalid battery status");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result pending after reset");

endmodule

bind battery_level_monitor_core blm_chk u_blm_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
